### design/srp_pkg.sv
// Package for the paged shelf rectangle packer: constants, types and codes.
`timescale 1ns / 1ps
package srp_pkg;
  localparam int unsigned MaxPages     = 8;
  localparam int unsigned MaxShelves   = 64;
  localparam int unsigned MaxPageSide  = 4096;
  localparam int unsigned DefaultSide  = 1024;
  localparam int unsigned PageW        = $clog2(MaxPages);
  localparam int unsigned ShelfW       = $clog2(MaxShelves);
  localparam int unsigned SlotW        = PageW + ShelfW;
  localparam int unsigned Slots        = MaxPages * MaxShelves;
  localparam int unsigned DimW         = 13;
  localparam int unsigned SumW         = 15;
  localparam int unsigned CountW       = ShelfW + 1;
  localparam int unsigned OpenW        = PageW + 1;
  localparam int unsigned ShelfWordW   = 3 * DimW;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatBlank = 2'd1;
  localparam logic [1:0] StatNoRoom = 2'd2;
  localparam logic [1:0] StatBig   = 2'd3;

  localparam logic [1:0] RegPageSize  = 2'd0;
  localparam logic [1:0] RegPageLimit = 2'd1;
  localparam logic [1:0] RegPad       = 2'd2;

  // one shelf entry: top, height, cursor
  typedef struct packed {
    logic [DimW-1:0] top;
    logic [DimW-1:0] tall;
    logic [DimW-1:0] cursor;
  } shelf_t;

  // per-page summary handed along the cell chain
  typedef struct packed {
    logic              hit;
    logic [PageW-1:0]  page;
    logic              new_shelf;
    logic [ShelfW-1:0] shelf;
  } find_t;
endpackage

### design/srp_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module srp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### design/srp_page_cell.sv
// One page cell: holds fill and shelf count of its page, tests a new shelf,
// and merges the first-fit result handed from the previous cell.
`timescale 1ns / 1ps
module srp_page_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [srp_pkg::PageW-1:0]     page_i,
  input  logic                          clear_i,
  input  logic                          open_i,
  input  logic                          commit_i,
  input  logic [srp_pkg::PageW-1:0]     commit_page_i,
  input  logic [srp_pkg::DimW-1:0]      h_i,
  input  logic [srp_pkg::DimW-1:0]      side_i,
  input  srp_pkg::find_t                prev_i,
  output srp_pkg::find_t                next_o,
  output logic [srp_pkg::DimW-1:0]      fill_o,
  output logic [srp_pkg::CountW-1:0]    total_o
);
  logic [srp_pkg::DimW-1:0]   fill_q, fill_d;
  logic [srp_pkg::CountW-1:0] total_q, total_d;
  logic [srp_pkg::SumW-1:0]   need;
  logic                       room;

  assign need = {2'b00, fill_q} + {2'b00, h_i};
  assign room = open_i && (total_q < srp_pkg::CountW'(srp_pkg::MaxShelves))
                && (need <= {2'b00, side_i});

  always_comb begin
    next_o = prev_i;
    if (!prev_i.hit && room) begin
      next_o.hit       = 1'b1;
      next_o.page      = page_i;
      next_o.new_shelf = 1'b1;
      next_o.shelf     = total_q[srp_pkg::ShelfW-1:0];
    end
    fill_d  = fill_q;
    total_d = total_q;
    if (clear_i) begin
      fill_d  = '0;
      total_d = '0;
    end else if (commit_i && commit_page_i == page_i) begin
      fill_d  = need[srp_pkg::DimW-1:0];
      total_d = total_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

  assign fill_o  = fill_q;
  assign total_o = total_q;
endmodule

### design/shelf_rect_packer_paged_top.sv
// Top level of the paged first-fit shelf rectangle packer.
//
// Input stream (s_axis): tuser = op (1 clear, 0 place), tdata = width, height.
// Output stream (m_axis): tdata = status, page_index, x_pos, y_pos.
// Configuration: cfg_we_i / cfg_idx_i / cfg_data_i write page_size,
// page_limit and pad_pixels. The user must write them only while the block
// is idle; the block itself does not enforce it. One item is handled at a
// time. A place item walks the open pages in order, and within a page its
// shelves, one shelf RAM read per shelf tested. When a page's shelves run
// out, a new shelf in that page is tried before the next page. Each shelf is
// read in StRead and tested in StTest, where a fit ends the walk; a new shelf,
// a new page or no room is settled in StWrite. Blank, oversized and clear
// items have their result in the cycle after acceptance.
// The new-shelf test runs in a chain of page cells, one per page.
// Reset empties all pages; shelf RAM contents are never read before written,
// so no clearing pass is needed. The result sits in an output register; while
// it waits for the receiver, no new item is taken.
`timescale 1ns / 1ps
module shelf_rect_packer_paged_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // rect_width[12:0], rect_height[25:13]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status[1:0], page_index[4:2], x_pos[16:5],
                                      // y_pos[28:17]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
  localparam int unsigned DW = srp_pkg::DimW;
  localparam int unsigned PW = srp_pkg::PageW;
  localparam int unsigned SW = srp_pkg::ShelfW;
  localparam int unsigned XW = srp_pkg::SumW;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRead  = 5'b00010,
    StTest  = 5'b00100,
    StWrite = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [12:0] size_q;
  logic [3:0]  limit_q;
  logic [7:0]  pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= 13'(srp_pkg::DefaultSide);
      limit_q <= 4'd1;
      pad_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srp_pkg::RegPageSize:  size_q  <= cfg_data_i;
        srp_pkg::RegPageLimit: limit_q <= cfg_data_i[3:0];
        srp_pkg::RegPad:       pad_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0]          side;
  logic [srp_pkg::OpenW-1:0] lim;
  always_comb begin
    side = size_q;
    if (size_q == '0) side = DW'(srp_pkg::DefaultSide);
    if (size_q > DW'(srp_pkg::MaxPageSide)) side = DW'(srp_pkg::MaxPageSide);
    lim = srp_pkg::OpenW'(limit_q);
    if (limit_q == '0) lim = srp_pkg::OpenW'(1);
    if (limit_q > 4'(srp_pkg::MaxPages)) lim = srp_pkg::OpenW'(srp_pkg::MaxPages);
  end

  logic [XW-1:0] w_pad, h_pad;
  assign w_pad = XW'(s_axis_tdata[12:0]) + XW'({pad_q, 1'b0});
  assign h_pad = XW'(s_axis_tdata[25:13]) + XW'({pad_q, 1'b0});

  logic [DW-1:0] w_q, h_q;
  logic [srp_pkg::OpenW-1:0] open_q, open_d;
  logic [PW-1:0] pg_q, pg_d;
  logic [SW:0]   sh_q, sh_d;
  logic [1:0]    stat_q, stat_d;
  logic [PW-1:0] opg_q, opg_d;
  logic [11:0]   ox_q, ox_d, oy_q, oy_d;
  logic          ovalid_q, ovalid_d;

  logic                   ram_we;
  logic [srp_pkg::SlotW-1:0] ram_wa, ram_ra;
  srp_pkg::shelf_t        ram_wd, ram_rd;

  srp_ram #(.Width(srp_pkg::ShelfWordW), .Depth(srp_pkg::Slots)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  // page cell chain
  srp_pkg::find_t          link [srp_pkg::MaxPages+1];
  logic [DW-1:0]           fill [srp_pkg::MaxPages];
  logic [srp_pkg::CountW-1:0] total [srp_pkg::MaxPages];
  logic                    clr, commit;
  logic [PW-1:0]           commit_pg;
  assign link[0] = '0;

  // a cell may take a new shelf if its page is open, or is the next page
  // and the limit allows opening it
  for (genvar g = 0; g < srp_pkg::MaxPages; g++) begin : g_cell
    srp_page_cell u_cell (
      .clk_i, .rst_ni,
      .page_i(PW'(g)),
      .clear_i(clr),
      .open_i((srp_pkg::OpenW'(g) < open_q) ||
              ((srp_pkg::OpenW'(g) == open_q) && (open_q < lim))),
      .commit_i(commit),
      .commit_page_i(commit_pg),
      .h_i(h_q),
      .side_i(side),
      .prev_i(link[g]),
      .next_o(link[g+1]),
      .fill_o(fill[g]),
      .total_o(total[g])
    );
  end

  srp_pkg::find_t fnd;
  assign fnd = link[srp_pkg::MaxPages];

  logic [XW-1:0] cur_sum;
  logic          shelf_fit, page_done;
  assign cur_sum   = XW'(ram_rd.cursor) + XW'(w_q);
  assign shelf_fit = (h_q <= ram_rd.tall) && (cur_sum <= XW'(side));
  assign page_done = (srp_pkg::CountW'(sh_q) >= total[pg_q]);

  assign s_axis_tready = (state_q == StIdle) && !ovalid_q;
  assign ram_ra = {pg_q, sh_q[SW-1:0]};

  always_comb begin
    state_d  = state_q;
    open_d   = open_q;
    pg_d     = pg_q;
    sh_d     = sh_q;
    stat_d   = stat_q;
    opg_d    = opg_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    ovalid_d = ovalid_q;
    clr      = 1'b0;
    commit   = 1'b0;
    commit_pg = fnd.page;
    ram_we   = 1'b0;
    ram_wa   = {pg_q, sh_q[SW-1:0]};
    ram_wd   = ram_rd;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          opg_d = '0; ox_d = '0; oy_d = '0; stat_d = srp_pkg::StatOk;
          pg_d = '0; sh_d = '0;
          if (s_axis_tuser) begin
            clr = 1'b1; open_d = '0; ovalid_d = 1'b1;
          end else if (s_axis_tdata[12:0] == '0 || s_axis_tdata[25:13] == '0) begin
            stat_d = srp_pkg::StatBlank; ovalid_d = 1'b1;
          end else if (w_pad > XW'(side) || h_pad > XW'(side)) begin
            stat_d = srp_pkg::StatBig; ovalid_d = 1'b1;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead: begin
        // shelves used up: new shelf here, else next page or StWrite; else test
        if (srp_pkg::OpenW'(pg_q) >= open_q) state_d = StWrite;
        else if (page_done) begin
          if (fnd.hit && fnd.page == pg_q) state_d = StWrite;
          else if (pg_q == PW'(srp_pkg::MaxPages - 1)) state_d = StWrite;
          else begin
            pg_d = pg_q + 1'b1; sh_d = '0;
          end
        end else state_d = StTest;
      end
      StTest: begin
        if (shelf_fit) begin
          ram_we = 1'b1;
          ram_wd.cursor = cur_sum[DW-1:0];
          opg_d = pg_q;
          ox_d = 12'(ram_rd.cursor + DW'(pad_q));
          oy_d = 12'(ram_rd.top + DW'(pad_q));
          ovalid_d = 1'b1;
          state_d = StIdle;
        end else begin
          sh_d = sh_q + 1'b1;
          state_d = StRead;
        end
      end
      StWrite: begin
        // new shelf in the current page or in the next page to open, else no room
        state_d = StIdle;
        ovalid_d = 1'b1;
        if (fnd.hit && (srp_pkg::OpenW'(fnd.page) <= open_q)) begin
          commit = 1'b1;
          ram_we = 1'b1;
          ram_wa = {fnd.page, fnd.shelf};
          ram_wd.top = fill[fnd.page];
          ram_wd.tall = h_q;
          ram_wd.cursor = w_q;
          if (srp_pkg::OpenW'(fnd.page) == open_q) open_d = open_q + 1'b1;
          opg_d = fnd.page;
          ox_d = 12'(pad_q);
          oy_d = 12'(fill[fnd.page] + DW'(pad_q));
        end else begin
          stat_d = srp_pkg::StatNoRoom;
          if (open_q < lim) open_d = open_q + 1'b1;
        end
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      open_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      open_q   <= open_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q <= pg_d; sh_q <= sh_d; stat_q <= stat_d;
    opg_q <= opg_d; ox_q <= ox_d; oy_q <= oy_d;
    if (s_axis_tvalid && s_axis_tready) begin
      w_q <= w_pad[DW-1:0];
      h_q <= h_pad[DW-1:0];
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, oy_q, ox_q, opg_q, stat_q};

`ifndef NO_ASSERTIONS
  a_open_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= srp_pkg::OpenW'(srp_pkg::MaxPages)) else $error("open pages over max");
  a_busy_noready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
`endif
endmodule

### dv/srp_checker.sv
// Checker for the shelf rectangle packer: predicts placements and compares results.
`timescale 1ns / 1ps
module srp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  // first member lands in the top bits: status ends up in bits [1:0]
  typedef struct packed {
    logic [11:0] y;
    logic [11:0] x;
    logic [2:0]  page;
    logic [1:0]  status;
  } place_t;

  place_t      exp_mem [1024];
  int unsigned wr_cnt, rd_cnt;

  int unsigned side_reg, limit_reg, pad_reg;
  int unsigned pages_open;
  int unsigned fill[srp_pkg::MaxPages];
  int unsigned nshelf[srp_pkg::MaxPages];
  int unsigned s_top[srp_pkg::Slots], s_tall[srp_pkg::Slots], s_cur[srp_pkg::Slots];

  function automatic bit try_page(int unsigned pg, int unsigned w, int unsigned h,
                                  int unsigned side, output int unsigned x,
                                  output int unsigned y);
    int unsigned k;
    x = 0; y = 0;
    for (int unsigned s = 0; s < nshelf[pg]; s++) begin
      k = pg * srp_pkg::MaxShelves + s;
      if (h <= s_tall[k] && s_cur[k] + w <= side) begin
        x = s_cur[k];
        y = s_top[k];
        s_cur[k] += w;
        return 1;
      end
    end
    if (nshelf[pg] < srp_pkg::MaxShelves && fill[pg] + h <= side) begin
      k = pg * srp_pkg::MaxShelves + nshelf[pg];
      s_top[k] = fill[pg];
      s_tall[k] = h;
      s_cur[k] = w;
      nshelf[pg]++;
      y = fill[pg];
      fill[pg] += h;
      return 1;
    end
    return 0;
  endfunction

  function automatic place_t predict_place(logic op, int unsigned rw, int unsigned rh);
    place_t r;
    int unsigned side, lim, w, h, x, y, pg;
    bit ok;
    r = '0;
    side = (side_reg == 0) ? srp_pkg::DefaultSide : side_reg;
    if (side > srp_pkg::MaxPageSide) side = srp_pkg::MaxPageSide;
    lim = (limit_reg == 0) ? 1 : limit_reg;
    if (lim > srp_pkg::MaxPages) lim = srp_pkg::MaxPages;
    ok = 0;
    if (op) begin
      pages_open = 0;
      for (int i = 0; i < srp_pkg::MaxPages; i++) begin
        fill[i] = 0;
        nshelf[i] = 0;
      end
      return r;
    end
    if (rw == 0 || rh == 0) begin
      r.status = srp_pkg::StatBlank;
      return r;
    end
    w = rw + 2 * pad_reg;
    h = rh + 2 * pad_reg;
    if (w > side || h > side) begin
      r.status = srp_pkg::StatBig;
      return r;
    end
    for (pg = 0; pg < pages_open; pg++) begin
      if (try_page(pg, w, h, side, x, y)) begin
        ok = 1;
        break;
      end
    end
    if (!ok && pages_open < lim) begin
      pg = pages_open;
      fill[pg] = 0;
      nshelf[pg] = 0;
      pages_open++;
      ok = try_page(pg, w, h, side, x, y);
    end
    if (!ok) begin
      r.status = srp_pkg::StatNoRoom;
      return r;
    end
    r.status = srp_pkg::StatOk;
    r.page = pg[2:0];
    r.x = 12'(x + pad_reg);
    r.y = 12'(y + pad_reg);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    place_t exp_r, got;
    if (!rst_ni) begin
      side_reg = srp_pkg::DefaultSide;
      limit_reg = 1;
      pad_reg = 0;
      pages_open = 0;
      for (int i = 0; i < srp_pkg::MaxPages; i++) begin
        fill[i] = 0;
        nshelf[i] = 0;
      end
      wr_cnt = 0;
      rd_cnt = 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srp_pkg::RegPageSize:  side_reg = 32'(cfg_data_i);
          srp_pkg::RegPageLimit: limit_reg = 32'(cfg_data_i[3:0]);
          srp_pkg::RegPad:       pad_reg = 32'(cfg_data_i[7:0]);
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[28:0];
        if (wr_cnt == rd_cnt) begin
          if (fail_count_o < 10) $display("unexpected result %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = exp_mem[rd_cnt[9:0]];
          rd_cnt++;
          if (got !== exp_r) begin
            if (fail_count_o < 10)
              $display("mismatch: exp st=%0d pg=%0d x=%0d y=%0d got st=%0d pg=%0d x=%0d y=%0d",
                       exp_r.status, exp_r.page, exp_r.x, exp_r.y,
                       got.status, got.page, got.x, got.y);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        exp_mem[wr_cnt[9:0]] = predict_place(s_axis_tuser, 32'(s_axis_tdata[12:0]),
                                             32'(s_axis_tdata[25:13]));
        wr_cnt++;
      end
    end
  end

  assign pending_o = int'(wr_cnt - rd_cnt);
endmodule

### dv/testbench.sv
// Testbench top: drives rectangles and configuration into the packer, gives the verdict.
`timescale 1ns / 1ps
module testbench;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;
  int          fail_count, pending;
  int unsigned cycles = 0;
  bit          hold_off = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  shelf_rect_packer_paged_top u_dut (.*);

  srp_checker u_chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 5000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall per result, long hold-off on request
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      m_axis_tready <= (gap == 0);
      if (gap != 0) begin
        repeat (gap) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      m_axis_tready <= 1'b0;
    end
  end

  // tvalid stays high after a transaction until the next item or a drain
  task automatic send_rect(logic op, int unsigned w, int unsigned h);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, h[12:0], w[12:0]};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n, int unsigned maxdim);
    int unsigned w, h;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: send_rect(1'b1, $urandom_range(0, 8191), $urandom_range(0, 8191));
        1: send_rect(1'b0, $urandom_range(0, 8191), $urandom_range(0, 8191));
        2: send_rect(1'b0, 0, $urandom_range(0, 8191));
        default: begin
          w = $urandom_range(1, maxdim);
          h = $urandom_range(1, maxdim);
          send_rect(1'b0, w, h);
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults (1024 side, one page, no padding)
    send_rect(1'b0, 0, 5);
    send_rect(1'b0, 5, 0);
    send_rect(1'b0, 1024, 1);
    send_rect(1'b0, 1025, 1);
    send_rect(1'b0, 1, 1025);
    send_rect(1'b0, 8191, 8191);
    send_rect(1'b0, 100, 100);
    send_rect(1'b0, 50, 60);
    send_rect(1'b0, 1024, 1024);
    send_rect(1'b1, 0, 0);
    send_rect(1'b0, 1024, 1024);
    send_rect(1'b0, 1, 1);
    drain();

    // page size 0 (default side), max pages, big pad: blank with padding, shelf limit
    write_reg(srp_pkg::RegPageSize, 13'd0);
    write_reg(srp_pkg::RegPageLimit, 13'd15);
    write_reg(srp_pkg::RegPad, 13'd255);
    send_rect(1'b0, 0, 3);
    send_rect(1'b0, 1, 1);
    send_rect(1'b0, 515, 1);
    send_rect(1'b1, 0, 0);
    drain();
    write_reg(srp_pkg::RegPad, 13'd0);
    write_reg(srp_pkg::RegPageSize, 13'd100);
    for (int i = 0; i < 66; i++) send_rect(1'b0, 100, 1);
    send_rect(1'b0, 1, 2);
    drain();
    write_reg(srp_pkg::RegPageSize, 13'h1FFF);
    send_rect(1'b0, 4096, 4096);
    send_rect(1'b0, 4097, 1);
    send_rect(1'b1, 8191, 8191);
    drain();

    // receiver holds off while the sender keeps offering
    write_reg(srp_pkg::RegPageSize, 13'd64);
    write_reg(srp_pkg::RegPageLimit, 13'd2);
    hold_off = 1;
    random_phase(20, 40);
    drain();

    // random phases through several settings
    for (int ph = 0; ph < 8; ph++) begin
      int unsigned side, lim, pd;
      side = (ph % 3 == 0) ? $urandom_range(16, 128) : $urandom_range(0, 4096);
      lim  = $urandom_range(0, 15);
      pd   = (ph % 2) ? $urandom_range(0, 4) : $urandom_range(0, 255);
      write_reg(srp_pkg::RegPageSize, side[12:0]);
      write_reg(srp_pkg::RegPageLimit, lim[12:0]);
      write_reg(srp_pkg::RegPad, pd[12:0]);
      send_rect(1'b1, 0, 0);
      random_phase(45, (ph % 3 == 0) ? 40 : 600);
      drain();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
